[rtl/bmp_pkg.sv]
// package: payload types, item indexes, result kinds, error codes and header constants
`default_nettype none
package bmp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        pixel;
    logic [3:0]         error_code;
    logic signed [31:0] image_width;
    logic signed [31:0] image_height;
  } out_item_t;

  // result kinds
  localparam logic [1:0] KIND_PIXEL    = 2'd0;
  localparam logic [1:0] KIND_FINISHED = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // error codes
  localparam logic [3:0] ERR_TRUNCATED    = 4'd0;
  localparam logic [3:0] ERR_MAGIC        = 4'd1;
  localparam logic [3:0] ERR_FILESIZE     = 4'd2;
  localparam logic [3:0] ERR_OFFSET       = 4'd3;
  localparam logic [3:0] ERR_OVERLAP      = 4'd4;
  localparam logic [3:0] ERR_DIBSIZE      = 4'd5;
  localparam logic [3:0] ERR_WIDTH        = 4'd6;
  localparam logic [3:0] ERR_HEIGHT       = 4'd7;
  localparam logic [3:0] ERR_PLANES       = 4'd8;
  localparam logic [3:0] ERR_BPP          = 4'd9;
  localparam logic [3:0] ERR_COMPRESSION  = 4'd10;
  localparam logic [3:0] ERR_IMAGESIZE    = 4'd11;
  localparam logic [3:0] ERR_MASK         = 4'd12;
  localparam logic [3:0] ERR_OFFSET_SHORT = 4'd13;

  // parse items
  localparam logic [4:0] IT_MAGIC   = 5'd0;
  localparam logic [4:0] IT_FSIZE   = 5'd1;
  localparam logic [4:0] IT_RES0    = 5'd2;
  localparam logic [4:0] IT_RES1    = 5'd3;
  localparam logic [4:0] IT_OFFSET  = 5'd4;
  localparam logic [4:0] IT_DIB     = 5'd5;
  localparam logic [4:0] IT_WIDTH   = 5'd6;
  localparam logic [4:0] IT_HEIGHT  = 5'd7;
  localparam logic [4:0] IT_PLANES  = 5'd8;
  localparam logic [4:0] IT_BPP     = 5'd9;
  localparam logic [4:0] IT_COMP    = 5'd10;
  localparam logic [4:0] IT_IMGSIZE = 5'd11;
  localparam logic [4:0] IT_MASK_R  = 5'd16;
  localparam logic [4:0] IT_MASK_G  = 5'd17;
  localparam logic [4:0] IT_MASK_B  = 5'd18;
  localparam logic [4:0] IT_GAP     = 5'd19;
  localparam logic [4:0] IT_ROW     = 5'd20;
  localparam logic [4:0] IT_PAD     = 5'd21;
  localparam logic [4:0] IT_TAIL    = 5'd22;
  localparam logic [4:0] IT_DONE    = 5'd23;

  localparam logic [31:0] HDR_END  = 32'd66;
  localparam logic [31:0] MAGIC_BM = 32'h0000_4D42;
  localparam logic [31:0] MASK_R   = 32'h0000_F800;
  localparam logic [31:0] MASK_G   = 32'h0000_07E0;
  localparam logic [31:0] MASK_B   = 32'h0000_001F;
  localparam logic [31:0] DIB_MIN  = 32'd40;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

[rtl/bmp_rgb565_stream_parser_top.sv]
// top level: byte stream in, pixel / finished / error transactions out
// usage:
// - input channel carries one file byte per transaction, or an end-of-file mark;
//   first_byte restarts parsing with that byte at file offset zero
// - output channel carries at most one transaction per input byte: a pixel,
//   a finished report or an error report with its code
// - one byte is taken every cycle while in_stall_o is low; the result of a byte appears in the output
//   register on the cycle after its transaction
// - the finished report for a file whose last byte is a pixel comes on the
//   next input transaction without first_byte
// - all header checks and pixel assembly run in combinational step logic
//   between the parse state registers and the output register
// - reset puts the parser at the magic number with an empty output register
// - when the receiver stalls a held result, in_stall_o rises and no byte is
//   taken until the result leaves
`default_nettype none
module bmp_rgb565_stream_parser_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire bmp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output bmp_pkg::out_item_t      out_data_o
);

  logic               accept;
  logic               res_valid;
  bmp_pkg::out_item_t res;
  logic               out_valid_q, out_valid_d;
  bmp_pkg::out_item_t out_data_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  bmp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .in_i        (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[rtl/bmp_core.sv]
// parse state registers and the per-byte step logic
`default_nettype none
module bmp_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire bmp_pkg::in_item_t  in_i,
  output logic                    res_valid_o,
  output bmp_pkg::out_item_t      res_o
);

  logic [4:0]  idx_q, idx_d;
  logic [31:0] bc_q, bc_d, start_q, start_d, acc_q, acc_d, skip_q, skip_d;
  logic [31:0] fsize_q, fsize_d, pstart_q, pstart_d, w_q, w_d, h_q, h_d, ib_q, ib_d;
  logic        stop_q, stop_d;
  logic [63:0] prod_q, prod_d;

  logic [31:0] pos, nlen, aw, ah, v, room;
  logic [33:0] flen;
  logic [39:0] pp;
  logic [63:0] pfull, pm;
  logic [64:0] want;
  logic        err_hit, pix_ready, enter_row;
  logic [3:0]  err_code;
  logic [15:0] pix;
  logic [1:0]  kind;

  always_comb begin
    idx_d = idx_q; bc_d = bc_q; start_d = start_q; acc_d = acc_q; skip_d = skip_q;
    fsize_d = fsize_q; pstart_d = pstart_q; w_d = w_q; h_d = h_q; ib_d = ib_q;
    stop_d = stop_q; prod_d = prod_q;
    pos = '0; nlen = '0; aw = '0; ah = '0; v = '0; room = '0; flen = '0; pp = '0;
    pfull = '0; pm = '0; want = '0; err_hit = 1'b0; err_code = bmp_pkg::ERR_TRUNCATED;
    pix_ready = 1'b0; enter_row = 1'b0; pix = '0; kind = bmp_pkg::KIND_PIXEL;
    res_valid_o = 1'b0;
    if (step_i) begin
      if (in_i.first_byte) begin
        idx_d = bmp_pkg::IT_MAGIC; bc_d = '0; start_d = '0; acc_d = '0; skip_d = '0;
        fsize_d = bmp_pkg::HDR_END; pstart_d = bmp_pkg::HDR_END; w_d = '0; h_d = '0;
        ib_d = '0; stop_d = 1'b0; prod_d = '0;
      end
      if (stop_d) begin
        // ignored until restart
      end else if (idx_d == bmp_pkg::IT_DONE) begin
        stop_d = 1'b1; res_valid_o = 1'b1; kind = bmp_pkg::KIND_FINISHED;
      end else if (in_i.end_of_file) begin
        stop_d = 1'b1; res_valid_o = 1'b1; kind = bmp_pkg::KIND_ERROR;
        err_code = bmp_pkg::ERR_TRUNCATED;
      end else begin
        pos = bc_d - start_d;
        aw = bmp_pkg::mag32(w_d);
        if (idx_d == bmp_pkg::IT_ROW) begin
          acc_d = acc_d | (32'(in_i.data_byte) << {pos[0], 3'b000});
          if (pos[0]) begin
            pix_ready = 1'b1;
            pix = acc_d[15:0];
            acc_d = '0;
          end
        end else if (idx_d < bmp_pkg::IT_GAP) begin
          acc_d = acc_d | (32'(in_i.data_byte) << {pos[1:0], 3'b000});
        end
        // width times raw height, one byte partial product per cycle in which a byte is taken
        if (idx_d == bmp_pkg::IT_HEIGHT) begin
          pp = 40'(aw) * 40'(in_i.data_byte);
          pfull = prod_d + (64'(pp) << {pos[1:0], 3'b000});
          prod_d = pfull;
        end
        bc_d = bc_d + 32'd1;
        nlen = bc_d - start_d;
        case (idx_d)
          bmp_pkg::IT_MAGIC, bmp_pkg::IT_RES0, bmp_pkg::IT_RES1,
          bmp_pkg::IT_PLANES, bmp_pkg::IT_BPP:                    flen = 34'd2;
          bmp_pkg::IT_GAP, bmp_pkg::IT_PAD, bmp_pkg::IT_TAIL:     flen = 34'(skip_d);
          bmp_pkg::IT_ROW:                                        flen = {1'b0, aw, 1'b0};
          default:                                                flen = 34'd4;
        endcase
        if ({2'b00, nlen} == flen) begin
          v = acc_d;
          room = fsize_d - pstart_d;
          case (idx_d)
            bmp_pkg::IT_MAGIC: begin
              if (v != bmp_pkg::MAGIC_BM) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_MAGIC; end
            end
            bmp_pkg::IT_FSIZE: begin
              if (v < bmp_pkg::HDR_END) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_FILESIZE;
              end else begin
                fsize_d = v;
              end
            end
            bmp_pkg::IT_OFFSET: begin
              if (v > fsize_d) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_OFFSET;
              end else if (v < bmp_pkg::HDR_END) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_OFFSET_SHORT;
              end else begin
                pstart_d = v;
              end
            end
            bmp_pkg::IT_DIB: begin
              if (v > pstart_d - 32'd14) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_OVERLAP;
              end else if (v < bmp_pkg::DIB_MIN) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_DIBSIZE;
              end
            end
            bmp_pkg::IT_WIDTH: begin
              if (v == '0 || {1'b0, bmp_pkg::mag32(v), 1'b0} > {2'b00, room}) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_WIDTH;
              end else begin
                w_d = v;
              end
            end
            bmp_pkg::IT_HEIGHT: begin
              ah = bmp_pkg::mag32(v);
              // negative height: aw*|h| = aw*2^32 - aw*h
              pm = v[31] ? ({aw, 32'd0} - pfull) : pfull;
              if (ah > room || {pm, 1'b0} > {33'd0, room}) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_HEIGHT;
              end else begin
                h_d = v;
                prod_d = pm;
              end
            end
            bmp_pkg::IT_PLANES: begin
              if (v != 32'd1) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_PLANES; end
            end
            bmp_pkg::IT_BPP: begin
              if (v != 32'd16) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_BPP; end
            end
            bmp_pkg::IT_COMP: begin
              if (v != 32'd3) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_COMPRESSION; end
            end
            bmp_pkg::IT_IMGSIZE: begin
              // padded row is 2*(aw + aw odd)
              ah = bmp_pkg::mag32(h_d);
              want = {prod_d, 1'b0} + (w_d[0] ? {32'd0, ah, 1'b0} : 65'd0);
              if ({33'd0, v} != want || want > {33'd0, room}) begin
                err_hit = 1'b1; err_code = bmp_pkg::ERR_IMAGESIZE;
              end else begin
                ib_d = v;
              end
            end
            bmp_pkg::IT_MASK_R: begin
              if (v != bmp_pkg::MASK_R) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_MASK; end
            end
            bmp_pkg::IT_MASK_G: begin
              if (v != bmp_pkg::MASK_G) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_MASK; end
            end
            bmp_pkg::IT_MASK_B: begin
              if (v != bmp_pkg::MASK_B) begin err_hit = 1'b1; err_code = bmp_pkg::ERR_MASK; end
            end
            default: ;
          endcase
          if (err_hit) begin
            stop_d = 1'b1; res_valid_o = 1'b1; kind = bmp_pkg::KIND_ERROR; pix = '0;
          end else begin
            acc_d = '0;
            if (idx_d == bmp_pkg::IT_TAIL || bc_d == fsize_d) begin
              res_valid_o = 1'b1;
              if (pix_ready) begin
                idx_d = bmp_pkg::IT_DONE;
                kind = bmp_pkg::KIND_PIXEL;
              end else begin
                stop_d = 1'b1;
                kind = bmp_pkg::KIND_FINISHED;
              end
            end else begin
              enter_row = {1'b0, bc_d} < (33'(pstart_d) + 33'(ib_d));
              case (idx_d)
                bmp_pkg::IT_MASK_B: begin
                  skip_d = pstart_d - bc_d;
                  if (skip_d != '0) begin
                    idx_d = bmp_pkg::IT_GAP;
                  end else if (enter_row) begin
                    idx_d = bmp_pkg::IT_ROW;
                  end else begin
                    idx_d = bmp_pkg::IT_TAIL; skip_d = fsize_d - bc_d;
                  end
                end
                bmp_pkg::IT_GAP, bmp_pkg::IT_PAD: begin
                  if (enter_row) begin
                    idx_d = bmp_pkg::IT_ROW;
                  end else begin
                    idx_d = bmp_pkg::IT_TAIL; skip_d = fsize_d - bc_d;
                  end
                end
                bmp_pkg::IT_ROW: begin
                  if (w_d[0]) begin
                    idx_d = bmp_pkg::IT_PAD; skip_d = 32'd2;
                  end else if (enter_row) begin
                    idx_d = bmp_pkg::IT_ROW;
                  end else begin
                    idx_d = bmp_pkg::IT_TAIL; skip_d = fsize_d - bc_d;
                  end
                end
                default: idx_d = idx_d + 5'd1;
              endcase
              start_d = bc_d;
              if (pix_ready) begin
                res_valid_o = 1'b1; kind = bmp_pkg::KIND_PIXEL;
              end
            end
          end
        end else if (pix_ready) begin
          res_valid_o = 1'b1; kind = bmp_pkg::KIND_PIXEL;
        end
      end
    end
    res_o.kind         = kind;
    res_o.pixel        = (kind == bmp_pkg::KIND_PIXEL) ? pix : 16'd0;
    res_o.error_code   = (kind == bmp_pkg::KIND_ERROR) ? err_code : bmp_pkg::ERR_TRUNCATED;
    res_o.image_width  = w_d;
    res_o.image_height = h_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= bmp_pkg::IT_MAGIC; bc_q <= '0; start_q <= '0; acc_q <= '0; skip_q <= '0;
      fsize_q <= bmp_pkg::HDR_END; pstart_q <= bmp_pkg::HDR_END; w_q <= '0; h_q <= '0;
      ib_q <= '0; stop_q <= 1'b0; prod_q <= '0;
    end else begin
      idx_q <= idx_d; bc_q <= bc_d; start_q <= start_d; acc_q <= acc_d; skip_q <= skip_d;
      fsize_q <= fsize_d; pstart_q <= pstart_d; w_q <= w_d; h_q <= h_d;
      ib_q <= ib_d; stop_q <= stop_d; prod_q <= prod_d;
    end
  end

endmodule
`default_nettype wire

[test/bmp_stream_checker.sv]
// checker: watches both channels, predicts parser results and compares them
`timescale 1ns / 100ps
module bmp_stream_checker
  import bmp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_data_i,
  output int             fail_cnt_o,
  output int             pending_o
);

  logic [4:0]  item_idx;
  logic [31:0] byte_cnt, field_base, accum, skip_len;
  logic [31:0] fsize, pix_base, wid, hgt, img_bytes;
  bit          halted;
  out_item_t   expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [31:0] magnitude(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  task automatic clear_parse();
    item_idx = IT_MAGIC; byte_cnt = '0; field_base = '0; accum = '0; skip_len = '0;
    fsize = HDR_END; pix_base = HDR_END; wid = '0; hgt = '0; img_bytes = '0;
    halted = 1'b0;
  endtask

  function automatic out_item_t make_result(logic [1:0] k, logic [15:0] p, logic [3:0] e);
    out_item_t r;
    r.kind = k; r.pixel = p; r.error_code = e;
    r.image_width = wid; r.image_height = hgt;
    return r;
  endfunction

  function automatic longint unsigned cur_len();
    case (item_idx)
      IT_MAGIC, IT_RES0, IT_RES1, IT_PLANES, IT_BPP: return 64'd2;
      IT_GAP, IT_PAD, IT_TAIL: return 64'(skip_len);
      IT_ROW: return 64'(magnitude(wid)) * 64'd2;
      default: return 64'd4;
    endcase
  endfunction

  // returns error code, or -1 when the field passes
  task automatic check_value(input logic [31:0] v, output int err);
    longint unsigned room, aw, ah, rb, want;
    room = 64'(fsize - pix_base);
    aw = 64'(magnitude(wid));
    err = -1;
    case (item_idx)
      IT_MAGIC: if (v != MAGIC_BM) err = int'(ERR_MAGIC);
      IT_FSIZE: if (v < HDR_END) err = int'(ERR_FILESIZE); else fsize = v;
      IT_OFFSET: begin
        if (v > fsize) err = int'(ERR_OFFSET);
        else if (v < HDR_END) err = int'(ERR_OFFSET_SHORT);
        else pix_base = v;
      end
      IT_DIB: begin
        if (v > pix_base - 32'd14) err = int'(ERR_OVERLAP);
        else if (v < DIB_MIN) err = int'(ERR_DIBSIZE);
      end
      IT_WIDTH: begin
        if (v == 0 || 64'(magnitude(v)) * 64'd2 > room) err = int'(ERR_WIDTH);
        else wid = v;
      end
      IT_HEIGHT: begin
        ah = 64'(magnitude(v));
        if (ah > room || aw * ah * 64'd2 > room) err = int'(ERR_HEIGHT);
        else hgt = v;
      end
      IT_PLANES: if (v != 1) err = int'(ERR_PLANES);
      IT_BPP: if (v != 16) err = int'(ERR_BPP);
      IT_COMP: if (v != 3) err = int'(ERR_COMPRESSION);
      IT_IMGSIZE: begin
        rb = aw * 64'd2;
        want = (rb + rb % 64'd4) * 64'(magnitude(hgt));
        if (64'(v) != want || want > room) err = int'(ERR_IMAGESIZE);
        else img_bytes = v;
      end
      IT_MASK_R: if (v != MASK_R) err = int'(ERR_MASK);
      IT_MASK_G: if (v != MASK_G) err = int'(ERR_MASK);
      IT_MASK_B: if (v != MASK_B) err = int'(ERR_MASK);
      default: ;
    endcase
  endtask

  task automatic start_pixels();
    if (64'(byte_cnt) < 64'(pix_base) + 64'(img_bytes)) begin
      item_idx = IT_ROW;
    end else begin
      item_idx = IT_TAIL;
      skip_len = fsize - byte_cnt;
    end
  endtask

  task automatic next_item();
    if (item_idx == IT_MASK_B) begin
      skip_len = pix_base - byte_cnt;
      if (skip_len != 0) item_idx = IT_GAP;
      else start_pixels();
    end else if (item_idx == IT_GAP || item_idx == IT_PAD) begin
      start_pixels();
    end else if (item_idx == IT_ROW) begin
      if (wid[0]) begin
        item_idx = IT_PAD;
        skip_len = 32'd2;
      end else begin
        start_pixels();
      end
    end else begin
      item_idx = item_idx + 5'd1;
    end
  endtask

  task automatic parse_byte(input in_item_t it, output bit has, output out_item_t r);
    logic [31:0] b, pos;
    logic [15:0] pix;
    bit          rdy;
    int          err;
    has = 1'b0; r = '0; rdy = 1'b0; pix = '0;
    b = {24'd0, it.data_byte};
    if (it.first_byte) clear_parse();
    if (halted) return;
    if (item_idx == IT_DONE) begin
      halted = 1'b1; has = 1'b1; r = make_result(KIND_FINISHED, '0, '0);
      return;
    end
    if (it.end_of_file) begin
      halted = 1'b1; has = 1'b1; r = make_result(KIND_ERROR, '0, ERR_TRUNCATED);
      return;
    end
    pos = byte_cnt - field_base;
    if (item_idx == IT_ROW) begin
      accum = accum | (b << (8 * pos[0]));
      if (pos[0]) begin
        rdy = 1'b1; pix = accum[15:0]; accum = '0;
      end
    end else if (item_idx < IT_GAP) begin
      accum = accum | (b << (8 * pos[1:0]));
    end
    byte_cnt = byte_cnt + 32'd1;
    if (64'(byte_cnt - field_base) == cur_len()) begin
      check_value(accum, err);
      if (err >= 0) begin
        halted = 1'b1; has = 1'b1; r = make_result(KIND_ERROR, '0, err[3:0]);
        return;
      end
      accum = '0;
      if (item_idx == IT_TAIL || byte_cnt == fsize) begin
        has = 1'b1;
        if (rdy) begin
          item_idx = IT_DONE;
          r = make_result(KIND_PIXEL, pix, '0);
        end else begin
          halted = 1'b1;
          r = make_result(KIND_FINISHED, '0, '0);
        end
        return;
      end
      next_item();
      field_base = byte_cnt;
    end
    if (rdy) begin
      has = 1'b1; r = make_result(KIND_PIXEL, pix, '0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit        has;
    out_item_t r, want;
    if (!rst_ni) begin
      clear_parse();
      expected_q.delete();
      fail_cnt_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        parse_byte(in_data_i, has, r);
        if (has) expected_q.push_back(r);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data_i);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.kind != out_data_i.kind || want.pixel != out_data_i.pixel ||
              want.error_code != out_data_i.error_code ||
              want.image_width != out_data_i.image_width ||
              want.image_height != out_data_i.image_height) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data_i);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

[test/tb_bmp_rgb565_stream_parser_top.sv]
// testbench top: builds bmp byte streams, drives the parser and reports the verdict
`timescale 1ns / 100ps
module tb_bmp_rgb565_stream_parser_top;
  import bmp_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_cnt, pending, sent, idle_cycles;
  bit        quiet = 1'b0;
  logic [7:0] file_q[$];

  localparam int WATCHDOG = 4000;

  bmp_rgb565_stream_parser_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  bmp_stream_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial forever #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(input logic [7:0] d, input bit eof, input bit fb);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: d, end_of_file: eof, first_byte: fb};
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_q.push_back(v[8*i +: 8]);
  endtask

  task automatic patch_le(input int at, input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_q[at + i] = v[8*i +: 8];
  endtask

  // well-formed rgb565 bitfields file into file_q
  task automatic build_file(input int w, input int h, input int gap, input int tail);
    int rb, img, offs;
    rb = 2 * (w < 0 ? -w : w);
    img = (rb + rb % 4) * (h < 0 ? -h : h);
    offs = 66 + gap;
    file_q.delete();
    put_le(MAGIC_BM, 2); put_le(offs + img + tail, 4);
    put_le($urandom, 2); put_le($urandom, 2);
    put_le(offs, 4); put_le($urandom_range(40, offs - 14), 4);
    put_le(w, 4); put_le(h, 4); put_le(32'd1, 2); put_le(32'd16, 2); put_le(32'd3, 4);
    put_le(img, 4);
    for (int i = 0; i < 4; i++) put_le($urandom, 4);
    put_le(MASK_R, 4); put_le(MASK_G, 4); put_le(MASK_B, 4);
    repeat (gap + img + tail) file_q.push_back(8'($urandom));
  endtask

  task automatic send_file(input int cut);
    for (int i = 0; i < file_q.size() && i < cut; i++) send(file_q[i], 1'b0, i == 0);
    if (cut < file_q.size()) send(8'($urandom), 1'b1, cut == 0);
  endtask

  task automatic random_file();
    build_file($urandom_range(0, 1) ? $urandom_range(1, 5) : -$urandom_range(1, 5),
               $urandom_range(0, 8) - 4, $urandom_range(0, 3), $urandom_range(0, 3));
  endtask

  initial begin
    int fld[12];
    int len[12];
    int k;
    fld = '{0, 2, 10, 14, 18, 22, 26, 28, 30, 34, 54, 58};
    len = '{2, 4, 4, 4, 4, 4, 2, 2, 4, 4, 4, 4};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // odd width with row padding, then even width ending on a pixel
    build_file(3, 2, 1, 0); send_file(file_q.size());
    build_file(2, -2, 0, 0); send_file(file_q.size()); send(8'hff, 1'b0, 1'b0);
    build_file(-1, 0, 2, 3); send_file(file_q.size());
    // one bad value per checked field, two for the offset, and of the masks only blue
    build_file(1, 1, 0, 0); patch_le(0, 32'h0000_4d43, 2); send_file(99);
    build_file(1, 1, 0, 0); patch_le(2, 32'd65, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(10, 32'hffff_ffff, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(10, 32'd65, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(14, 32'd53, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(14, 32'd39, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(18, 32'd0, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(22, 32'h8000_0000, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(26, 32'd2, 2); send_file(99);
    build_file(1, 1, 0, 0); patch_le(28, 32'd24, 2); send_file(99);
    build_file(1, 1, 0, 0); patch_le(30, 32'd0, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(34, 32'd2, 4); send_file(99);
    build_file(1, 1, 0, 0); patch_le(62, 32'h3f, 4); send_file(99);
    // early end of stream, and end of stream on a restart
    build_file(2, 1, 0, 0); send_file(40);
    send_file(0);
    send(8'h00, 1'b0, 1'b0);

    while (sent < 1400) begin
      if (sent > 1200) quiet = 1'b1;
      random_file();
      k = $urandom_range(0, 99);
      if (k < 65) begin
        send_file(file_q.size());
        if ($urandom_range(0, 2) == 0) send(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      end else if (k < 85) begin
        k = $urandom_range(0, 11);
        if ($urandom_range(0, 1)) patch_le(fld[k], $urandom, len[k]);
        else file_q[fld[k] + $urandom_range(0, len[k] - 1)] ^= 8'(1 << $urandom_range(0, 7));
        send_file(file_q.size());
      end else if (k < 95) begin
        send_file($urandom_range(0, file_q.size() - 1));
      end else begin
        repeat ($urandom_range(1, 10))
          send(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bmp_pkg.sv
rtl/bmp_core.sv
rtl/bmp_rgb565_stream_parser_top.sv
test/bmp_stream_checker.sv
test/tb_bmp_rgb565_stream_parser_top.sv
